FILE: hdl/pfs_pkg.sv
// Shared constants and types of the Peskin force spreader.
package pfs_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    CFG_OFFSET_X  = 3'd0,
    CFG_OFFSET_Y  = 3'd1,
    CFG_OFFSET_Z  = 3'd2,
    CFG_GRAVITY_X = 3'd3,
    CFG_GRAVITY_Y = 3'd4,
    CFG_GRAVITY_Z = 3'd5
  } cfg_idx_t;

  // Distance width: Q16 distances up to two lattice units.
  localparam int RW   = 18;
  // Square-root argument (Q32) and root (Q16) widths.
  localparam int AW   = 34;
  localparam int QW   = 17;
  // Weight width in Q16.
  localparam int WW   = 16;
  // Cycles from the distance input to the weight register.
  localparam int WLAT = QW + 3;

  // Distance of one node from the particle on one axis.
  typedef struct packed {
    logic [RW-1:0] r;
    logic          near;
    logic          zero;
  } dist_t;

endpackage

FILE: hdl/pfs_weight.sv
// Pipelined Peskin four-point weight for one axis, one node per cycle while en is high.
module pfs_weight (
  input  logic                    clk,
  input  logic                    en,
  input  pfs_pkg::dist_t          dist_in,
  output logic [pfs_pkg::WW-1:0]  w_out
);

  localparam int RW  = pfs_pkg::RW;
  localparam int AW  = pfs_pkg::AW;
  localparam int QW  = pfs_pkg::QW;
  localparam int RMW = AW + 1;

  pfs_pkg::dist_t d0_r;
  pfs_pkg::dist_t d1_r;
  logic [AW-1:0]  arg1_r;
  logic [AW-1:0]  arg1_nxt;

  logic [RMW-1:0] rem_r [QW];
  logic [QW-1:0]  q_r   [QW];
  pfs_pkg::dist_t ds_r  [QW];
  logic [RMW-1:0] rem_nxt [QW];
  logic [QW-1:0]  q_nxt   [QW];

  logic [pfs_pkg::WW-1:0] w_r;
  logic [pfs_pkg::WW-1:0] w_nxt;

  // Square-root argument: 1 + 4r - 4r^2 near the node, -7 + 12r - 4r^2 further out.
  always_comb begin
    logic [2*RW-1:0]    sq;
    logic signed [39:0] arg_s;
    sq = d0_r.r * d0_r.r;
    if (d0_r.near) begin
      arg_s = 40'sh1_0000_0000 + $signed(40'({d0_r.r, 18'h0})) - $signed(40'({sq, 2'b00}));
    end else begin
      arg_s = $signed(40'({d0_r.r, 18'h0})) + $signed(40'({d0_r.r, 19'h0}))
              - 40'sh7_0000_0000 - $signed(40'({sq, 2'b00}));
    end
    if (arg_s < 0) begin
      arg1_nxt = '0;
    end else begin
      arg1_nxt = arg_s[AW-1:0];
    end
  end

  // One root bit per stage, most significant first.
  always_comb begin
    logic [RMW-1:0] rin;
    logic [RMW-1:0] trial;
    logic [QW-1:0]  qin;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rin = RMW'(arg1_r);
        qin = '0;
      end else begin
        rin = rem_r[k-1];
        qin = q_r[k-1];
      end
      trial = (RMW'(qin) << (QW - k)) + (RMW'(1) << (2 * (QW - 1 - k)));
      if (rin >= trial) begin
        rem_nxt[k] = rin - trial;
        q_nxt[k]   = qin | (QW'(1) << (QW - 1 - k));
      end else begin
        rem_nxt[k] = rin;
        q_nxt[k]   = qin;
      end
    end
  end

  // Weight from distance and root, clamped at zero and divided by eight.
  always_comb begin
    logic signed [20:0] wv;
    pfs_pkg::dist_t     dl;
    dl = ds_r[QW-1];
    if (dl.near) begin
      wv = 21'sd196608 - $signed(21'({dl.r, 1'b0})) + $signed(21'(q_r[QW-1]));
    end else begin
      wv = 21'sd327680 - $signed(21'({dl.r, 1'b0})) - $signed(21'(q_r[QW-1]));
    end
    if (dl.zero || wv < 0) begin
      w_nxt = '0;
    end else begin
      w_nxt = wv[18:3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0_r   <= dist_in;
      d1_r   <= d0_r;
      arg1_r <= arg1_nxt;
      for (int k = 0; k < QW; k++) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
        ds_r[k]  <= (k == 0) ? d1_r : ds_r[k-1];
      end
      w_r <= w_nxt;
    end
  end

  assign w_out = w_r;

endmodule

FILE: hdl/peskin_force_spreader_core.sv
// Top level of the Peskin four-point force spreader.
//
// The in_ channel takes one particle position per word (x, y, z in unsigned
// Q12.16). For every lattice node in the clipped 4x4x4 neighbourhood the out_
// channel gives one word: the node indices and the gravity vector scaled by
// the product of three Peskin weights, k running fastest; tlast marks the
// final node of a particle. A particle outside the domain gives no word.
// The cfg_ port writes offsets and gravity; the user must do so only while the
// block is idle, which the block itself does not enforce. A node generator
// issues one node per cycle, while the receiver does not stall, into a 24-stage
// pipeline (three square-root pipelines of 17 stages, then the weight products
// and force multipliers). The next position is accepted once the last node of
// the current particle has been issued. Reset clears the offsets, gravity and
// all valid bits. When the receiver stalls, the whole pipeline and the
// generator hold; nothing is lost.
module peskin_force_spreader_core #(
  parameter int LOCAL_NX = 32,
  parameter int LOCAL_NY = 32,
  parameter int LOCAL_NZ = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x [27:0], pos_y [55:28], pos_z [83:56], zero padding
  input  logic [87:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // node_i [5:0], node_j [11:6], node_k [17:12], force_x [49:18],
  // force_y [81:50], force_z [113:82], zero padding
  output logic [119:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  localparam int IWX  = $clog2(LOCAL_NX + 1);
  localparam int IWY  = $clog2(LOCAL_NY + 1);
  localparam int IWZ  = $clog2(LOCAL_NZ + 1);
  localparam int WW   = pfs_pkg::WW;
  localparam int WLAT = pfs_pkg::WLAT;

  typedef struct packed {
    logic signed [28:0] p;
    logic signed [14:0] lo;
    logic signed [14:0] hi;
  } axis_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] i;
    logic [5:0] j;
    logic [5:0] k;
    logic       last;
  } side_t;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  // Local position and clipped node range of one axis.
  function automatic axis_t calc_axis(logic [27:0] pos, logic [11:0] off,
                                      logic signed [14:0] n);
    axis_t              a;
    logic signed [14:0] fl;
    a.p  = $signed({1'b0, pos}) - $signed({1'b0, off, 16'h0});
    fl   = {{2{a.p[28]}}, a.p[28:16]};
    a.lo = fl - 15'sd1;
    a.hi = fl + $signed({14'h0, |a.p[15:0]}) + 15'sd1;
    if (a.lo < 15'sd1) begin
      a.lo = 15'sd1;
    end
    if (a.hi > n) begin
      a.hi = n;
    end
    return a;
  endfunction

  // Distance of a node from the particle with its branch flags.
  function automatic pfs_pkg::dist_t calc_dist(logic signed [28:0] p, logic [26:0] node);
    pfs_pkg::dist_t     d;
    logic signed [29:0] dv;
    logic [29:0]        ad;
    dv     = {p[28], p} - $signed({3'b000, node});
    ad     = dv[29] ? 30'(-dv) : 30'(dv);
    d.zero = ad > 30'h20000;
    d.near = ad <= 30'h10000;
    d.r    = d.zero ? '0 : ad[pfs_pkg::RW-1:0];
    return d;
  endfunction

  // Configuration registers.
  logic [11:0]        off_x_r, off_y_r, off_z_r;
  logic signed [31:0] grav_x_r, grav_y_r, grav_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r  <= '0;
      off_y_r  <= '0;
      off_z_r  <= '0;
      grav_x_r <= '0;
      grav_y_r <= '0;
      grav_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfs_pkg::CFG_OFFSET_X:  off_x_r  <= cfg_wdata[11:0];
        pfs_pkg::CFG_OFFSET_Y:  off_y_r  <= cfg_wdata[11:0];
        pfs_pkg::CFG_OFFSET_Z:  off_z_r  <= cfg_wdata[11:0];
        pfs_pkg::CFG_GRAVITY_X: grav_x_r <= cfg_wdata;
        pfs_pkg::CFG_GRAVITY_Y: grav_y_r <= cfg_wdata;
        pfs_pkg::CFG_GRAVITY_Z: grav_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline advance: everything moves unless a finished word is held.
  logic en;
  logic out_valid_r;
  assign en = !out_valid_r || out_tready;

  // Node generator.
  state_t             state_r;
  logic signed [28:0] px_r, py_r, pz_r;
  logic [IWX-1:0]     ilo_r, ihi_r, i_r;
  logic [IWY-1:0]     jlo_r, jhi_r, j_r;
  logic [IWZ-1:0]     klo_r, khi_r, k_r;
  axis_t              ax, ay, az;
  logic               empty;
  logic               last_iss;
  logic               issue;

  assign ax = calc_axis(in_tdata[27:0],  off_x_r, 15'(LOCAL_NX));
  assign ay = calc_axis(in_tdata[55:28], off_y_r, 15'(LOCAL_NY));
  assign az = calc_axis(in_tdata[83:56], off_z_r, 15'(LOCAL_NZ));
  assign empty = (ax.lo > ax.hi) || (ay.lo > ay.hi) || (az.lo > az.hi);

  assign in_tready = (state_r == ST_IDLE);
  assign issue     = (state_r == ST_RUN) && en;
  assign last_iss  = (i_r == ihi_r) && (j_r == jhi_r) && (k_r == khi_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid && !empty) begin
            state_r <= ST_RUN;
            px_r    <= ax.p;
            py_r    <= ay.p;
            pz_r    <= az.p;
            ilo_r   <= IWX'(ax.lo);
            ihi_r   <= IWX'(ax.hi);
            jlo_r   <= IWY'(ay.lo);
            jhi_r   <= IWY'(ay.hi);
            klo_r   <= IWZ'(az.lo);
            khi_r   <= IWZ'(az.hi);
            i_r     <= IWX'(ax.lo);
            j_r     <= IWY'(ay.lo);
            k_r     <= IWZ'(az.lo);
          end
        end
        ST_RUN: begin
          if (en) begin
            if (k_r != khi_r) begin
              k_r <= k_r + 1'b1;
            end else begin
              k_r <= klo_r;
              if (j_r != jhi_r) begin
                j_r <= j_r + 1'b1;
              end else begin
                j_r <= jlo_r;
                if (i_r != ihi_r) begin
                  i_r <= i_r + 1'b1;
                end else begin
                  state_r <= ST_IDLE;
                end
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Per-axis weight pipelines.
  logic [WW-1:0] wx, wy, wz;

  pfs_weight u_wx (
    .clk(clk), .en(en), .dist_in(calc_dist(px_r, 27'({i_r, 16'h0}))), .w_out(wx));
  pfs_weight u_wy (
    .clk(clk), .en(en), .dist_in(calc_dist(py_r, 27'({j_r, 16'h0}))), .w_out(wy));
  pfs_weight u_wz (
    .clk(clk), .en(en), .dist_in(calc_dist(pz_r, 27'({k_r, 16'h0}))), .w_out(wz));

  // Node indices and valid bits travel beside the weight pipelines.
  side_t         sb_r [WLAT];
  side_t         sb_iss;
  side_t         sb_p1_r, sb_p2_r, sb_f1_r;
  logic [WW-1:0] wxy_p1_r, wz_p1_r, w_p2_r;
  logic signed [48:0] fx_f1_r, fy_f1_r, fz_f1_r;
  logic [31:0]   fx_r, fy_r, fz_r;
  logic [5:0]    oi_r, oj_r, ok_r;
  logic          olast_r;
  logic [2*WW-1:0] wxy_prod, w_prod;

  assign sb_iss.valid = issue;
  assign sb_iss.i     = 6'(i_r);
  assign sb_iss.j     = 6'(j_r);
  assign sb_iss.k     = 6'(k_r);
  assign sb_iss.last  = last_iss;

  assign wxy_prod = wx * wy;
  assign w_prod   = wxy_p1_r * wz_p1_r;

  // Saturate a shifted force to the signed 32-bit range.
  function automatic logic [31:0] sat_force(logic signed [48:0] prod);
    logic signed [32:0] f;
    f = prod[48:16];
    if (f > 33'sh0_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end else if (f < -33'sh0_8000_0000) begin
      return 32'h8000_0000;
    end
    return f[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < WLAT; s++) begin
        sb_r[s].valid <= 1'b0;
      end
      sb_p1_r.valid <= 1'b0;
      sb_p2_r.valid <= 1'b0;
      sb_f1_r.valid <= 1'b0;
      out_valid_r   <= 1'b0;
    end else if (en) begin
      for (int s = 0; s < WLAT; s++) begin
        sb_r[s] <= (s == 0) ? sb_iss : sb_r[s-1];
      end
      sb_p1_r     <= sb_r[WLAT-1];
      sb_p2_r     <= sb_p1_r;
      sb_f1_r     <= sb_p2_r;
      out_valid_r <= sb_f1_r.valid;
    end
  end

  // Weight products, force multiplication and output register.
  always_ff @(posedge clk) begin
    if (en) begin
      wxy_p1_r <= wxy_prod[2*WW-1:16];
      wz_p1_r  <= wz;
      w_p2_r   <= w_prod[2*WW-1:16];
      fx_f1_r  <= grav_x_r * $signed({1'b0, w_p2_r});
      fy_f1_r  <= grav_y_r * $signed({1'b0, w_p2_r});
      fz_f1_r  <= grav_z_r * $signed({1'b0, w_p2_r});
      fx_r     <= sat_force(fx_f1_r);
      fy_r     <= sat_force(fy_f1_r);
      fz_r     <= sat_force(fz_f1_r);
      oi_r     <= sb_f1_r.i;
      oj_r     <= sb_f1_r.j;
      ok_r     <= sb_f1_r.k;
      olast_r  <= sb_f1_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {6'h0, fz_r, fy_r, fx_r, ok_r, oj_r, oi_r};

`ifndef SYNTHESIS
  // The combined weight can never exceed an eighth of a lattice unit.
  a_weight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sb_p2_r.valid |-> w_p2_r <= 16'h2000)
    else $error("weight product out of range");

  // Issuing the final node of a particle frees the input.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && last_iss) |=> in_tready)
    else $error("generator did not return to idle after last node");

  // A node with the last flag leaves the generator marked valid.
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (en && issue && last_iss) |=> sb_r[0].valid && sb_r[0].last)
    else $error("last node lost at issue");
`endif

endmodule
